FILE: sv/pcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants for the staggered pixel crossfade.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int PIXEL_COUNT = 256;
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = 8;
    localparam int RANK_W      = 8;
    localparam int TIME_W      = 20;
    localparam int COL_W       = 24;
    localparam int CH_W        = 8;
    localparam int NUM_W       = TIME_W + CH_W;
    localparam int DIV_BITS    = CH_W;

    typedef enum logic [2:0] {
        FUNC_RANK     = 3'd0,
        FUNC_TIMING   = 3'd1,
        FUNC_INITIAL  = 3'd2,
        FUNC_FINAL    = 3'd3,
        FUNC_GENERATE = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        CLS_BEFORE,
        CLS_BLEND,
        CLS_AFTER,
        CLS_NONE
    } t_fade_cls;

    // One write word for the tables, already gated by acceptance.
    typedef struct packed {
        logic              we_rank;
        logic              we_timing;
        logic              we_init;
        logic              we_final;
        logic [IDX_W-1:0]  idx;
        logic [RANK_W-1:0] rank;
        logic [TIME_W-1:0] start;
        logic [TIME_W-1:0] span;
        logic [COL_W-1:0]  colour;
    } t_wr_cmd;

    // Sideband carried alongside the dividers.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        t_fade_cls        cls;
        logic [COL_W-1:0] init;
        logic [COL_W-1:0] fin;
    } t_side;

endpackage

FILE: sv/pcf_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_tables
// Per-LED and per-rank memories. The rank read at the LED index addresses
// the timing read that follows; colours are delayed to line up.
// ----------------------------------------------------------------------------
module pcf_tables (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  pcf_pkg::t_wr_cmd              i_wr,
    input  logic [pcf_pkg::IDX_W-1:0]     i_rd_idx,
    output logic [pcf_pkg::TIME_W-1:0]    o_start,
    output logic [pcf_pkg::TIME_W-1:0]    o_span,
    output logic                          o_rank_ok,
    output logic [pcf_pkg::COL_W-1:0]     o_init,
    output logic [pcf_pkg::COL_W-1:0]     o_final
);

    logic [pcf_pkg::RANK_W-1:0] m_rank  [pcf_pkg::TABLE_DEPTH];
    logic [pcf_pkg::TIME_W-1:0] m_start [pcf_pkg::TABLE_DEPTH];
    logic [pcf_pkg::TIME_W-1:0] m_span  [pcf_pkg::TABLE_DEPTH];
    logic [pcf_pkg::COL_W-1:0]  m_init  [pcf_pkg::TABLE_DEPTH];
    logic [pcf_pkg::COL_W-1:0]  m_final [pcf_pkg::TABLE_DEPTH];

    logic [pcf_pkg::TABLE_DEPTH-1:0] r_col_vld;

    logic [pcf_pkg::RANK_W-1:0] r_rank;
    logic [pcf_pkg::COL_W-1:0]  r_init1;
    logic [pcf_pkg::COL_W-1:0]  r_final1;
    logic                       r_col1_vld;
    logic [pcf_pkg::COL_W-1:0]  r_init2;
    logic [pcf_pkg::COL_W-1:0]  r_final2;
    logic [pcf_pkg::TIME_W-1:0] r_start;
    logic [pcf_pkg::TIME_W-1:0] r_span;
    logic                       r_rank_ok;

    // Memory writes. The first colour write to an LED also blacks out the
    // other colour entry, so one valid bit covers both colour memories.
    always_ff @(posedge i_clk) begin
        if (i_wr.we_rank) begin
            m_rank[i_wr.idx] <= i_wr.rank;
        end
        if (i_wr.we_timing) begin
            m_start[i_wr.idx] <= i_wr.start;
            m_span[i_wr.idx]  <= i_wr.span;
        end
        if (i_wr.we_init) begin
            m_init[i_wr.idx] <= i_wr.colour;
            if (!r_col_vld[i_wr.idx]) begin
                m_final[i_wr.idx] <= '0;
            end
        end
        if (i_wr.we_final) begin
            m_final[i_wr.idx] <= i_wr.colour;
            if (!r_col_vld[i_wr.idx]) begin
                m_init[i_wr.idx] <= '0;
            end
        end
    end

    // Colour valid bits: an LED with no colour write reads as black.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_vld <= '0;
        end else begin
            if (i_wr.we_init || i_wr.we_final) begin
                r_col_vld[i_wr.idx] <= 1'b1;
            end
        end
    end

    // First read stage: rank and colours at the LED index.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rank     <= m_rank[i_rd_idx];
            r_init1    <= m_init[i_rd_idx];
            r_final1   <= m_final[i_rd_idx];
            r_col1_vld <= r_col_vld[i_rd_idx];
        end
    end

    // Second read stage: timing at the rank.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_start   <= m_start[r_rank];
            r_span    <= m_span[r_rank];
            r_rank_ok <= (32'(r_rank) < pcf_pkg::PIXEL_COUNT);
            r_init2   <= r_col1_vld ? r_init1 : '0;
            r_final2  <= r_col1_vld ? r_final1 : '0;
        end
    end

    assign o_start   = r_start;
    assign o_span    = r_span;
    assign o_rank_ok = r_rank_ok;
    assign o_init    = r_init2;
    assign o_final   = r_final2;

endmodule

FILE: sv/pcf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_divider
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit in DIV_BITS bits.
// ----------------------------------------------------------------------------
module pcf_divider (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [pcf_pkg::NUM_W-1:0]     i_num,
    input  logic [pcf_pkg::TIME_W-1:0]    i_den,
    output logic [pcf_pkg::DIV_BITS-1:0]  o_quot
);

    logic [pcf_pkg::NUM_W-1:0]    r_rem [pcf_pkg::DIV_BITS];
    logic [pcf_pkg::TIME_W-1:0]   r_den [pcf_pkg::DIV_BITS];
    logic [pcf_pkg::DIV_BITS-1:0] r_q   [pcf_pkg::DIV_BITS];

    // Each stage tries the divisor shifted to its bit position.
    for (genvar s = 0; s < pcf_pkg::DIV_BITS; s++) begin : g_stage
        logic [pcf_pkg::NUM_W-1:0]    w_rem;
        logic [pcf_pkg::TIME_W-1:0]   w_den;
        logic [pcf_pkg::DIV_BITS-1:0] w_q;
        logic [pcf_pkg::NUM_W-1:0]    w_sh;
        logic                         w_ge;

        if (s == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_den = r_den[s-1];
            assign w_q   = r_q[s-1];
        end

        assign w_sh = pcf_pkg::NUM_W'(w_den) << (pcf_pkg::DIV_BITS - 1 - s);
        assign w_ge = (w_rem >= w_sh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? (w_rem - w_sh) : w_rem;
                r_den[s] <= w_den;
                r_q[s]   <= {w_q[pcf_pkg::DIV_BITS-2:0], w_ge};
            end
        end
    end

    assign o_quot = r_q[pcf_pkg::DIV_BITS-1];

endmodule

FILE: sv/staggered_pixel_crossfade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staggered_pixel_crossfade
// Per-LED staggered linear RGB crossfade with table writes and generation.
// A generate word passes through two table reads, compare, multiply,
// eight divider stages and the output register.
// Throughput: one word per cycle; the whole pipeline holds only while a
// finished result is stalled at the output.
// Reset clears the pipeline valids and the colour valid bits at once;
// rank and timing tables are undefined until written.
// ----------------------------------------------------------------------------
module staggered_pixel_crossfade (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_func,
    input  logic [pcf_pkg::IDX_W-1:0]     i_index,
    input  logic [pcf_pkg::RANK_W-1:0]    i_rank,
    input  logic [pcf_pkg::TIME_W-1:0]    i_time_ms,
    input  logic [pcf_pkg::TIME_W-1:0]    i_span_ms,
    input  logic [pcf_pkg::COL_W-1:0]     i_colour,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pcf_pkg::IDX_W-1:0]     o_pixel_index,
    output logic [pcf_pkg::COL_W-1:0]     o_pixel_colour,
    output logic                          o_fade_done
);

    logic             w_en;
    logic             w_acc;
    logic             w_in_range;
    pcf_pkg::t_wr_cmd w_wr;

    logic [pcf_pkg::TIME_W-1:0] w_start;
    logic [pcf_pkg::TIME_W-1:0] w_span;
    logic                       w_rank_ok;
    logic [pcf_pkg::COL_W-1:0]  w_init;
    logic [pcf_pkg::COL_W-1:0]  w_final;

    // Stage 1 and 2 sideband.
    logic                        r1_vld, r2_vld;
    logic                        r1_ok, r2_ok;
    logic [pcf_pkg::IDX_W-1:0]   r1_idx, r2_idx;
    logic [pcf_pkg::TIME_W-1:0]  r1_tm, r2_tm;

    // Stage 3: classification.
    pcf_pkg::t_side              r3_side;
    pcf_pkg::t_side              n3_side;
    logic [pcf_pkg::TIME_W-1:0]  r3_dt, n3_dt;
    logic [pcf_pkg::TIME_W-1:0]  r3_span;

    // Stage 4: products.
    pcf_pkg::t_side              r4_side;
    logic [pcf_pkg::TIME_W-1:0]  r4_span;
    logic [pcf_pkg::NUM_W-1:0]   r4_num [6];

    pcf_pkg::t_side              r_dl [pcf_pkg::DIV_BITS];
    logic [pcf_pkg::DIV_BITS-1:0] w_quot [6];

    logic                        r_o_valid;
    logic [pcf_pkg::IDX_W-1:0]   r_o_idx;
    logic [pcf_pkg::COL_W-1:0]   r_o_colour, n_o_colour;
    logic                        r_o_done, n_o_done;

    logic [pcf_pkg::TIME_W:0]    w_end;
    logic [pcf_pkg::TIME_W-1:0]  w_st_eff;
    logic [pcf_pkg::TIME_W-1:0]  w_sp_eff;

    // Pipeline advances unless a finished word is held at the output.
    assign w_en       = !r_o_valid || !i_stall;
    assign o_stall    = !w_en;
    assign w_acc      = i_valid && w_en;
    assign w_in_range = (32'(i_index) < pcf_pkg::PIXEL_COUNT);

    // Table write word.
    always_comb begin
        w_wr           = '0;
        w_wr.idx       = i_index;
        w_wr.rank      = i_rank;
        w_wr.start     = i_time_ms;
        w_wr.span      = i_span_ms;
        w_wr.colour    = i_colour;
        w_wr.we_rank   = w_acc && w_in_range && (i_func == pcf_pkg::FUNC_RANK);
        w_wr.we_timing = w_acc && w_in_range && (i_func == pcf_pkg::FUNC_TIMING);
        w_wr.we_init   = w_acc && w_in_range && (i_func == pcf_pkg::FUNC_INITIAL);
        w_wr.we_final  = w_acc && w_in_range && (i_func == pcf_pkg::FUNC_FINAL);
    end

    pcf_tables u_tables (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_wr      (w_wr),
        .i_rd_idx  (i_index),
        .o_start   (w_start),
        .o_span    (w_span),
        .o_rank_ok (w_rank_ok),
        .o_init    (w_init),
        .o_final   (w_final)
    );

    // Valid bits of the early stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid && (i_func == pcf_pkg::FUNC_GENERATE);
            r2_vld <= r1_vld;
        end
    end

    // Sideband of the early stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_idx <= i_index;
            r1_tm  <= i_time_ms;
            r1_ok  <= w_in_range;
            r2_idx <= r1_idx;
            r2_tm  <= r1_tm;
            r2_ok  <= r1_ok;
        end
    end

    // Compare the time with the fade window.
    always_comb begin
        w_st_eff      = w_rank_ok ? w_start : '0;
        w_sp_eff      = w_rank_ok ? w_span : '0;
        w_end         = {1'b0, w_st_eff} + {1'b0, w_sp_eff};
        n3_side.valid = r2_vld;
        n3_side.idx   = r2_idx;
        n3_side.init  = w_init;
        n3_side.fin   = w_final;
        n3_dt         = r2_tm - w_st_eff;
        if (!r2_ok) begin
            n3_side.cls = pcf_pkg::CLS_NONE;
        end else if (r2_tm < w_st_eff) begin
            n3_side.cls = pcf_pkg::CLS_BEFORE;
        end else if ({1'b0, r2_tm} >= w_end) begin
            n3_side.cls = pcf_pkg::CLS_AFTER;
        end else begin
            n3_side.cls = pcf_pkg::CLS_BLEND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side.valid <= 1'b0;
        end else if (w_en) begin
            r3_side.valid <= n3_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_side.idx  <= n3_side.idx;
            r3_side.cls  <= n3_side.cls;
            r3_side.init <= n3_side.init;
            r3_side.fin  <= n3_side.fin;
            r3_dt        <= n3_dt;
            r3_span      <= w_sp_eff;
        end
    end

    // Weighted products per channel: start weight on even, end on odd.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_side.valid <= 1'b0;
        end else if (w_en) begin
            r4_side.valid <= r3_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_side.idx  <= r3_side.idx;
            r4_side.cls  <= r3_side.cls;
            r4_side.init <= r3_side.init;
            r4_side.fin  <= r3_side.fin;
            r4_span      <= r3_span;
            for (int c = 0; c < 3; c++) begin
                r4_num[2*c]   <= pcf_pkg::NUM_W'(r3_span - r3_dt)
                               * pcf_pkg::NUM_W'(r3_side.init[c*8 +: 8]);
                r4_num[2*c+1] <= pcf_pkg::NUM_W'(r3_dt)
                               * pcf_pkg::NUM_W'(r3_side.fin[c*8 +: 8]);
            end
        end
    end

    for (genvar d = 0; d < 6; d++) begin : g_div
        pcf_divider u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r4_num[d]),
            .i_den  (r4_span),
            .o_quot (w_quot[d])
        );
    end

    // Sideband delay matching the divider depth; only the valids are reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pcf_pkg::DIV_BITS; k++) begin
                r_dl[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_dl[0] <= r4_side;
            for (int k = 1; k < pcf_pkg::DIV_BITS; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // Select the result colour.
    always_comb begin
        n_o_colour = '0;
        n_o_done   = 1'b0;
        case (r_dl[pcf_pkg::DIV_BITS-1].cls)
            pcf_pkg::CLS_BEFORE: begin
                n_o_colour = r_dl[pcf_pkg::DIV_BITS-1].init;
            end
            pcf_pkg::CLS_AFTER: begin
                n_o_colour = r_dl[pcf_pkg::DIV_BITS-1].fin;
                n_o_done   = 1'b1;
            end
            pcf_pkg::CLS_BLEND: begin
                for (int c = 0; c < 3; c++) begin
                    n_o_colour[c*8 +: 8] = w_quot[2*c] + w_quot[2*c+1];
                end
            end
            default: begin
                n_o_done = 1'b1;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_dl[pcf_pkg::DIV_BITS-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_idx    <= r_dl[pcf_pkg::DIV_BITS-1].idx;
            r_o_colour <= n_o_colour;
            r_o_done   <= n_o_done;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_pixel_index  = r_o_idx;
    assign o_pixel_colour = r_o_colour;
    assign o_fade_done    = r_o_done;

    // The input is held off only by a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_o_valid && i_stall))
        else $error("input held without a stalled result");

    // An accepted generate word enters the first stage.
    a_gen_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_func == pcf_pkg::FUNC_GENERATE)) |=> r1_vld)
        else $error("generate word lost at entry");

    // Write words never produce a pipeline entry.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_func != pcf_pkg::FUNC_GENERATE)) |=> !r1_vld)
        else $error("write word produced a result");

    // A pixel before its start is never marked done.
    a_before_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_dl[pcf_pkg::DIV_BITS-1].valid
         && (r_dl[pcf_pkg::DIV_BITS-1].cls == pcf_pkg::CLS_BEFORE)) |=> !r_o_done)
        else $error("done set before fade start");

endmodule

FILE: verif/crossfade_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crossfade_checker
// Watches both channels of the staggered pixel crossfade, keeps its own copy
// of the fade tables, predicts each generated pixel and compares it.
// ----------------------------------------------------------------------------
module crossfade_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [2:0]                 i_func,
    input  logic [pcf_pkg::IDX_W-1:0]  i_index,
    input  logic [pcf_pkg::RANK_W-1:0] i_rank,
    input  logic [pcf_pkg::TIME_W-1:0] i_time_ms,
    input  logic [pcf_pkg::TIME_W-1:0] i_span_ms,
    input  logic [pcf_pkg::COL_W-1:0]  i_colour,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [pcf_pkg::IDX_W-1:0]  i_pixel_index,
    input  logic [pcf_pkg::COL_W-1:0]  i_pixel_colour,
    input  logic                       i_fade_done,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_pixels_seen,
    output int                         o_blends_seen
);

    typedef struct packed {
        logic [pcf_pkg::IDX_W-1:0] idx;
        logic [pcf_pkg::COL_W-1:0] colour;
        logic                      done;
        logic                      blend;
    } t_pixel;

    logic [pcf_pkg::RANK_W-1:0] led_rank   [pcf_pkg::TABLE_DEPTH];
    logic [pcf_pkg::TIME_W-1:0] rank_start [pcf_pkg::TABLE_DEPTH];
    logic [pcf_pkg::TIME_W-1:0] rank_span  [pcf_pkg::TABLE_DEPTH];
    logic [pcf_pkg::COL_W-1:0]  led_init   [pcf_pkg::TABLE_DEPTH];
    logic [pcf_pkg::COL_W-1:0]  led_final  [pcf_pkg::TABLE_DEPTH];
    t_pixel                     pixel_queue[$];

    // One channel of the linear mix, with both divisions truncating.
    function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] e,
                                               input longint dt, input longint dur);
        longint v;
        v = ((dur - dt) * s) / dur + (dt * e) / dur;
        return v[7:0];
    endfunction

    function automatic t_pixel predict_pixel(input logic [pcf_pkg::IDX_W-1:0] idx,
                                             input logic [pcf_pkg::TIME_W-1:0] tm);
        t_pixel p;
        logic [pcf_pkg::RANK_W-1:0] r;
        longint st, sp, dt;
        p.idx = idx;
        p.blend = 1'b0;
        r = led_rank[idx];
        st = 0;
        sp = 0;
        if (r < pcf_pkg::PIXEL_COUNT) begin
            st = rank_start[r];
            sp = rank_span[r];
        end
        if (idx >= pcf_pkg::PIXEL_COUNT) begin
            p.colour = '0;
            p.done = 1'b1;
        end else if (tm < st) begin
            p.colour = led_init[idx];
            p.done = 1'b0;
        end else if (tm >= st + sp) begin
            p.colour = led_final[idx];
            p.done = 1'b1;
        end else begin
            dt = tm - st;
            p.blend = 1'b1;
            p.done = 1'b0;
            p.colour = {mix_channel(led_init[idx][23:16], led_final[idx][23:16], dt, sp),
                        mix_channel(led_init[idx][15:8], led_final[idx][15:8], dt, sp),
                        mix_channel(led_init[idx][7:0], led_final[idx][7:0], dt, sp)};
        end
        return p;
    endfunction

    assign o_pending = pixel_queue.size();

    // Update the tables on accepted words and compare accepted pixels.
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_pixels_seen <= 0;
            o_blends_seen <= 0;
            pixel_queue.delete();
            for (int k = 0; k < pcf_pkg::TABLE_DEPTH; k++) begin
                led_init[k] = '0;
                led_final[k] = '0;
                led_rank[k] = '0;
                rank_start[k] = '0;
                rank_span[k] = '0;
            end
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pixel_queue.size() == 0) begin
                    $display("%0t: unexpected pixel idx %0d colour %h", $time,
                             i_pixel_index, i_pixel_colour);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pixel_queue.pop_front();
                    o_pixels_seen <= o_pixels_seen + 1;
                    if (want.blend) o_blends_seen <= o_blends_seen + 1;
                    if (want.idx !== i_pixel_index || want.colour !== i_pixel_colour
                        || want.done !== i_fade_done) begin
                        $display({"%0t: mismatch expected idx %0d colour %h done %b,",
                                  " got idx %0d colour %h done %b"},
                                 $time, want.idx, want.colour, want.done,
                                 i_pixel_index, i_pixel_colour, i_fade_done);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func == pcf_pkg::FUNC_GENERATE) begin
                    pixel_queue.push_back(predict_pixel(i_index, i_time_ms));
                end else if (i_index < pcf_pkg::PIXEL_COUNT) begin
                    case (i_func)
                        pcf_pkg::FUNC_RANK:    led_rank[i_index] = i_rank;
                        pcf_pkg::FUNC_TIMING: begin
                            rank_start[i_index] = i_time_ms;
                            rank_span[i_index] = i_span_ms;
                        end
                        pcf_pkg::FUNC_INITIAL: led_init[i_index] = i_colour;
                        pcf_pkg::FUNC_FINAL:   led_final[i_index] = i_colour;
                        default: ;
                    endcase
                end
            end
        end
    end
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the staggered pixel crossfade: fills the rank and timing tables, then mixes
// table writes and generate words under varying idle and stall pressure.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 200000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [2:0]                 func = '0;
    logic [pcf_pkg::IDX_W-1:0]  index = '0;
    logic [pcf_pkg::RANK_W-1:0] rank = '0;
    logic [pcf_pkg::TIME_W-1:0] time_ms = '0;
    logic [pcf_pkg::TIME_W-1:0] span_ms = '0;
    logic [pcf_pkg::COL_W-1:0]  colour = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [pcf_pkg::IDX_W-1:0]  pixel_index;
    logic [pcf_pkg::COL_W-1:0]  pixel_colour;
    logic                       fade_done;
    int                         errors, pending, pixels_seen, blends_seen;
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;
    logic                       hold_go = 1'b0;
    logic                       hold_active = 1'b0;
    int                         cycles = 0;
    int                         words_sent = 0;

    always #4 i_clk = ~i_clk;

    staggered_pixel_crossfade dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_func(func), .i_index(index), .i_rank(rank), .i_time_ms(time_ms),
        .i_span_ms(span_ms), .i_colour(colour), .o_valid(out_valid),
        .i_stall(out_stall), .o_pixel_index(pixel_index),
        .o_pixel_colour(pixel_colour), .o_fade_done(fade_done)
    );

    crossfade_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_index(index), .i_rank(rank), .i_time_ms(time_ms),
        .i_span_ms(span_ms), .i_colour(colour), .i_out_valid(out_valid),
        .i_out_stall(out_stall), .i_pixel_index(pixel_index),
        .i_pixel_colour(pixel_colour), .i_fade_done(fade_done), .o_errors(errors),
        .o_pending(pending), .o_pixels_seen(pixels_seen), .o_blends_seen(blends_seen)
    );

    // Long receiver hold-off, counted in cycles once requested.
    initial begin : p_hold
        int n;
        @(posedge hold_go);
        hold_active <= 1'b1;
        for (n = 0; n < 60; n++) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Receiver stalls: the long hold-off when active, else random.
    always @(posedge i_clk) begin
        if (hold_active) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Offer one word, with random idle gaps first, and wait for acceptance.
    task automatic send_word(input logic [31:0] f, input logic [31:0] ix,
                             input logic [31:0] rk, input logic [31:0] tm,
                             input logic [31:0] sp, input logic [31:0] col);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        func <= f[2:0];
        index <= ix[pcf_pkg::IDX_W-1:0];
        rank <= rk[pcf_pkg::RANK_W-1:0];
        time_ms <= tm[pcf_pkg::TIME_W-1:0];
        span_ms <= sp[pcf_pkg::TIME_W-1:0];
        colour <= col[pcf_pkg::COL_W-1:0];
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // A random word: mostly generates near fade windows, some writes and noise.
    task automatic random_word();
        int pick;
        logic [31:0] led;
        logic [31:0] tm;
        pick = $urandom_range(99);
        led = $urandom_range(15);
        if ($urandom_range(9) == 0) led = $urandom;
        if (pick < 55) begin
            tm = $urandom_range(2000);
            if ($urandom_range(19) == 0) tm = $urandom;
            send_word(pcf_pkg::FUNC_GENERATE, led, $urandom, tm, $urandom, $urandom);
        end else if (pick < 65) begin
            send_word(pcf_pkg::FUNC_RANK, led, $urandom_range(15), $urandom, $urandom,
                      $urandom);
        end else if (pick < 75) begin
            send_word(pcf_pkg::FUNC_TIMING, $urandom_range(15), $urandom,
                      $urandom_range(1200), $urandom_range(900), $urandom);
        end else if (pick < 85) begin
            send_word(pcf_pkg::FUNC_INITIAL, led, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 95) begin
            send_word(pcf_pkg::FUNC_FINAL, led, $urandom, $urandom, $urandom, $urandom);
        end else begin
            send_word($urandom_range(7, 5), $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Give every LED and rank a defined rank and timing before any read.
        for (int k = 0; k < pcf_pkg::TABLE_DEPTH; k++) begin
            send_word(pcf_pkg::FUNC_RANK, k, k % 16, 0, 0, 0);
            send_word(pcf_pkg::FUNC_TIMING, k, 0, 100 * (k % 16), 200 + k, 0);
        end
        // Directed: black default, extremes, zero span, highest rank.
        send_word(pcf_pkg::FUNC_GENERATE, 3, 0, 0, 0, 0);
        send_word(pcf_pkg::FUNC_INITIAL, 3, 0, 0, 0, 24'hFFFFFF);
        send_word(pcf_pkg::FUNC_FINAL, 3, 0, 0, 0, 24'h000000);
        send_word(pcf_pkg::FUNC_GENERATE, 3, 0, 300, 0, 0);
        send_word(pcf_pkg::FUNC_GENERATE, 3, 0, 350, 0, 0);
        send_word(pcf_pkg::FUNC_GENERATE, 3, 0, 700, 0, 0);
        send_word(pcf_pkg::FUNC_GENERATE, 3, 0, 20'hFFFFF, 0, 0);
        send_word(pcf_pkg::FUNC_TIMING, 255, 0, 20'hFFFFF, 20'hFFFFF, 0);
        send_word(pcf_pkg::FUNC_RANK, 255, 255, 0, 0, 0);
        send_word(pcf_pkg::FUNC_FINAL, 255, 0, 0, 0, 24'hA5C3FF);
        send_word(pcf_pkg::FUNC_GENERATE, 255, 0, 20'hFFFFE, 0, 0);
        send_word(pcf_pkg::FUNC_GENERATE, 255, 0, 20'hFFFFF, 0, 0);
        send_word(pcf_pkg::FUNC_TIMING, 5, 0, 500, 0, 0);
        send_word(pcf_pkg::FUNC_GENERATE, 5, 0, 499, 0, 0);
        send_word(pcf_pkg::FUNC_GENERATE, 5, 0, 500, 0, 0);
        send_word(pcf_pkg::FUNC_GENERATE, 0, 0, 0, 0, 0);
        send_word(3'd7, 8'hFF, 8'hFF, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF);
        send_word(3'd5, 0, 0, 0, 0, 0);
        drain_results();

        // Long receiver hold-off while the sender keeps offering.
        hold_go <= 1'b1;
        repeat (40) begin
            send_word(pcf_pkg::FUNC_GENERATE, $urandom_range(15), 0,
                      $urandom_range(2000), 0, 0);
        end
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 74 : 24) : 0;
            recv_stall_pct = (phase == 2) ? 74 : ((phase == 3) ? 24 : 0);
            repeat (110) random_word();
            drain_results();
        end

        $display("tb_top: %0d words sent, %0d pixels checked, %0d mid-fade blends.",
                 words_sent, pixels_seen, blends_seen);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
